[sv/tpe_pkg.sv]
// Shared types, constants and a helper function of the trajectory polynomial evaluator.
package tpe_pkg;

    localparam int VALUE_W = 48;
    localparam int TIME_W  = 20;
    localparam int SEG_W   = 4;
    localparam int AXIS_W  = 2;
    localparam int POWER_W = 3;
    localparam int WEIGHT_W = 6;
    localparam int AXES    = 3;
    localparam int ORDERS  = 3;
    localparam int FRAC_SHIFT = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [VALUE_W-1:0] tpe_value_t;
    typedef logic [TIME_W-1:0]         tpe_time_t;
    typedef logic [SEG_W-1:0]          tpe_seg_t;
    typedef logic [AXIS_W-1:0]         tpe_axis_t;
    typedef logic [POWER_W-1:0]        tpe_power_t;
    typedef logic [WEIGHT_W-1:0]       tpe_weight_t;

    // Controls for the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } tpe_mac_ctrl_t;

    // Derivative weight of the term in t^j: 1, j or j*(j-1).
    function automatic tpe_weight_t tpe_weight(input logic [1:0] order, input tpe_power_t j);
        tpe_weight_t jw;
        tpe_weight_t w;
        jw = tpe_weight_t'(j);
        case (order)
            2'd0:    w = tpe_weight_t'(1);
            2'd1:    w = jw;
            2'd2:    w = tpe_weight_t'(jw * (jw - tpe_weight_t'(1)));
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[sv/tpe_if.sv]
// Request and response channel interfaces of the trajectory polynomial evaluator.
interface tpe_req_if;
    logic                valid;
    logic                ready;
    logic                operation;
    tpe_pkg::tpe_seg_t   segment;
    tpe_pkg::tpe_axis_t  axis;
    tpe_pkg::tpe_power_t power;
    tpe_pkg::tpe_value_t coefficient;
    tpe_pkg::tpe_time_t  local_time;

    modport source (output valid, output operation, output segment, output axis,
                    output power, output coefficient, output local_time, input ready);
    modport sink   (input valid, input operation, input segment, input axis,
                    input power, input coefficient, input local_time, output ready);
endinterface

interface tpe_rsp_if;
    logic                valid;
    logic                ready;
    tpe_pkg::tpe_value_t pos_x;
    tpe_pkg::tpe_value_t pos_y;
    tpe_pkg::tpe_value_t pos_z;
    tpe_pkg::tpe_value_t vel_x;
    tpe_pkg::tpe_value_t vel_y;
    tpe_pkg::tpe_value_t vel_z;
    tpe_pkg::tpe_value_t acc_x;
    tpe_pkg::tpe_value_t acc_y;
    tpe_pkg::tpe_value_t acc_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z,
                    output acc_x, output acc_y, output acc_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input vel_x, input vel_y, input vel_z,
                    input acc_x, input acc_y, input acc_z, output ready);
endinterface

[sv/tpe_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/tpe_mac.sv]
// Shared Horner multiply-accumulate unit with truncation and saturation.
module tpe_mac (
    input  logic                  clk,
    input  tpe_pkg::tpe_mac_ctrl_t ctrl,
    input  tpe_pkg::tpe_value_t   coeff,
    input  tpe_pkg::tpe_weight_t  weight,
    input  tpe_pkg::tpe_time_t    t,
    output tpe_pkg::tpe_value_t   acc_sum
);
    import tpe_pkg::*;

    localparam int PROD_W = VALUE_W + TIME_W + 1;
    localparam int WC_W   = VALUE_W + WEIGHT_W + 1;
    localparam int SUM_W  = WC_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WC_W-1:0]   wc_reg;
    tpe_value_t               acc_reg;
    logic signed [SUM_W-1:0]  sum;

    // Sum of the truncated product and the weighted coefficient, then clamped.
    always_comb
    begin
        sum = SUM_W'($signed(prod_reg[PROD_W-1:FRAC_SHIFT])) + SUM_W'(wc_reg);
        if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1)
        begin
            acc_sum = sum[VALUE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            acc_sum = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            acc_sum = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // Multiply stage and accumulate stage of one Horner step.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= acc_reg * $signed({1'b0, t});
            wc_reg   <= $signed({1'b0, weight}) * coeff;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_sum;
        end
    end

endmodule

[sv/trajectory_polynomial_evaluator.sv]
// Top level: coefficient store, Horner sequencer and result register.
// A load transaction is taken while the block stays idle and ready for the next request.
// A query reads the store once per evaluation and runs each Horner step through the shared
// multiply-accumulate in a multiply state and an accumulate state, then hands the results
// over to the output register.
// Reset clears the sequencer and output valid; the coefficient store is not cleared.
module trajectory_polynomial_evaluator #(
    parameter int MAX_SEGMENTS    = 16,
    parameter int COEFFS_PER_AXIS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    tpe_req_if.sink   req,
    tpe_rsp_if.source rsp
);
    import tpe_pkg::*;

    localparam int DEPTH = MAX_SEGMENTS * AXES * COEFFS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = $clog2(COEFFS_PER_AXIS);

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_DONE} state_t;

    state_t        state_reg, state_next;
    tpe_seg_t      seg_reg, seg_next;
    tpe_time_t     t_reg, t_next;
    logic [1:0]    order_reg, order_next;
    logic [1:0]    axis_reg, axis_next;
    logic [JW-1:0] j_reg, j_next;
    tpe_value_t    res_reg [ORDERS][AXES];
    tpe_value_t    res_next [ORDERS][AXES];
    tpe_value_t    out_reg [ORDERS][AXES];
    logic          out_valid_reg, out_valid_next;
    logic          out_load;

    logic          accept;
    logic          load_ok;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [JW-1:0] rd_j;
    tpe_value_t    rdata;
    tpe_value_t    acc_sum;
    tpe_mac_ctrl_t mac_ctrl;
    logic          last_term;
    logic          no_terms;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Load addressing and range check.
    assign load_ok = (32'(req.segment) < MAX_SEGMENTS) && (32'(req.axis) < AXES)
                     && (32'(req.power) < COEFFS_PER_AXIS);
    assign we      = accept && (req.operation == OP_LOAD) && load_ok;
    assign waddr   = AW'((32'(req.segment) * AXES + 32'(req.axis)) * COEFFS_PER_AXIS
                         + 32'(req.power));

    // Read the current term, or the next lower one while a step completes.
    assign rd_j  = (state_reg == ST_ACC) ? j_reg - JW'(1) : j_reg;
    assign raddr = AW'((32'(seg_reg) * AXES + 32'(axis_reg)) * COEFFS_PER_AXIS + 32'(rd_j));

    assign last_term = (32'(j_reg) == 32'(order_reg));
    assign no_terms  = (32'(order_reg) > COEFFS_PER_AXIS - 1);

    tpe_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(req.coefficient),
        .raddr(raddr),
        .rdata(rdata)
    );

    tpe_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .coeff  (rdata),
        .weight (tpe_weight(order_reg, POWER_W'(j_reg))),
        .t      (t_reg),
        .acc_sum(acc_sum)
    );

    // Sequencer over derivative orders, axes and Horner terms.
    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        t_next         = t_reg;
        order_next     = order_reg;
        axis_next      = axis_reg;
        j_next         = j_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;
        mac_ctrl       = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.operation == OP_QUERY)
                begin
                    seg_next   = req.segment;
                    t_next     = req.local_time;
                    order_next = '0;
                    axis_next  = '0;
                    j_next     = JW'(COEFFS_PER_AXIS - 1);
                    mac_ctrl.clear = 1'b1;
                    if (32'(req.segment) < MAX_SEGMENTS)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        for (int o = 0; o < ORDERS; o++)
                        begin
                            for (int a = 0; a < AXES; a++)
                            begin
                                res_next[o][a] = '0;
                            end
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                if (no_terms)
                begin
                    res_next[order_reg][axis_reg] = '0;
                    if (order_reg == 2'(ORDERS - 1) && axis_reg == 2'(AXES - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else if (axis_reg == 2'(AXES - 1))
                    begin
                        axis_next  = '0;
                        order_next = order_reg + 2'd1;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                state_next      = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_term)
                begin
                    // Evaluation finished: store it and move to the next one.
                    res_next[order_reg][axis_reg] = acc_sum;
                    mac_ctrl.clear = 1'b1;
                    j_next         = JW'(COEFFS_PER_AXIS - 1);
                    if (order_reg == 2'(ORDERS - 1) && axis_reg == 2'(AXES - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (axis_reg == 2'(AXES - 1))
                        begin
                            axis_next  = '0;
                            order_next = order_reg + 2'd1;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                end
                else
                begin
                    mac_ctrl.acc_en = 1'b1;
                    j_next          = j_reg - JW'(1);
                    state_next      = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // Hand the results over once the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control registers and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg   <= seg_next;
        t_reg     <= t_next;
        order_reg <= order_next;
        axis_reg  <= axis_next;
        j_reg     <= j_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Response channel.
    assign rsp.valid = out_valid_reg;
    assign rsp.pos_x = out_reg[0][0];
    assign rsp.pos_y = out_reg[0][1];
    assign rsp.pos_z = out_reg[0][2];
    assign rsp.vel_x = out_reg[1][0];
    assign rsp.vel_y = out_reg[1][1];
    assign rsp.vel_z = out_reg[1][2];
    assign rsp.acc_x = out_reg[2][0];
    assign rsp.acc_y = out_reg[2][1];
    assign rsp.acc_z = out_reg[2][2];

endmodule

[test/tb.sv]
// Self-checking testbench for the trajectory polynomial evaluator, with its own Horner predictor.
module tb;
    import tpe_pkg::*;

    localparam int MAX_SEGMENTS = 16;
    localparam int COEFFS       = 8;
    localparam int FIELDS       = ORDERS * AXES;
    localparam int TOTAL_ITEMS  = 950;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int REPORT_LIMIT = 100;

    localparam tpe_value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam tpe_value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam tpe_value_t VALUE_ONE = tpe_value_t'(64'h1_0000_0000);
    localparam logic signed [71:0] WIDE_MAX = VALUE_MAX;
    localparam logic signed [71:0] WIDE_MIN = VALUE_MIN;

    // One result: index is derivative order times three plus axis, position x in the low word.
    typedef logic [FIELDS-1:0][VALUE_W-1:0] kinematics_t;

    typedef struct packed {
        logic       operation;
        tpe_seg_t   segment;
        tpe_axis_t  axis;
        tpe_power_t power;
        tpe_value_t coefficient;
        tpe_time_t  local_time;
    } request_t;

    // Keeps a shadow coefficient table and the queue of predicted results.
    class kinematics_scoreboard;
        tpe_value_t  coeff_store [MAX_SEGMENTS][AXES][COEFFS];
        kinematics_t expected_motion [$];
        string       field_names [FIELDS] = '{"pos_x", "pos_y", "pos_z",
                                               "vel_x", "vel_y", "vel_z",
                                               "acc_x", "acc_y", "acc_z"};
        int errors;
        int loads;
        int ignored_loads;
        int queries;
        int checked;
        int saturations;

        // Horner evaluation of one derivative of one axis, saturating at every step.
        function tpe_value_t evaluate_derivative(tpe_seg_t seg, int ax, int order, tpe_time_t t);
            logic signed [71:0] acc;
            logic signed [71:0] prod;
            logic signed [71:0] sum;
            int j;
            int w;
            acc = '0;
            for (j = COEFFS - 1; j >= order; j--)
            begin
                w = (order == 0) ? 1 : (order == 1) ? j : j * (j - 1);
                prod = acc * $signed({1'b0, t});
                prod = prod >>> FRAC_SHIFT;
                sum = prod + coeff_store[seg][ax][j] * w;
                if (sum > WIDE_MAX)
                begin
                    acc = WIDE_MAX;
                    saturations++;
                end
                else if (sum < WIDE_MIN)
                begin
                    acc = WIDE_MIN;
                    saturations++;
                end
                else
                begin
                    acc = sum;
                end
            end
            return acc[VALUE_W-1:0];
        endfunction

        // Applies an accepted request transaction to the shadow state.
        function void note_request(request_t r);
            kinematics_t motion;
            int order;
            int ax;
            if (r.operation == OP_LOAD)
            begin
                loads++;
                if (r.axis < AXES && r.power < COEFFS && r.segment < MAX_SEGMENTS)
                    coeff_store[r.segment][r.axis][r.power] = r.coefficient;
                else
                    ignored_loads++;
            end
            else
            begin
                queries++;
                motion = '0;
                if (r.segment < MAX_SEGMENTS)
                begin
                    for (order = 0; order < ORDERS; order++)
                        for (ax = 0; ax < AXES; ax++)
                            motion[order*AXES + ax] =
                                evaluate_derivative(r.segment, ax, order, r.local_time);
                end
                expected_motion.push_back(motion);
            end
        endfunction

        // Compares an accepted response transaction with the oldest prediction.
        function void check_response(kinematics_t got);
            kinematics_t want;
            int k;
            if (expected_motion.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("response transaction with no query outstanding");
                return;
            end
            want = expected_motion.pop_front();
            checked++;
            for (k = 0; k < FIELDS; k++)
            begin
                if (got[k] !== want[k])
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $error("%s: expected %h, got %h", field_names[k], want[k], got[k]);
                end
            end
        endfunction

        function int pending();
            return expected_motion.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tpe_req_if req_ch ();
    tpe_rsp_if rsp_ch ();

    trajectory_polynomial_evaluator #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .COEFFS_PER_AXIS (COEFFS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    kinematics_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ask       = 0;
    int counted        = 0;
    int cycle_count    = 0;
    bit coeff_loaded [MAX_SEGMENTS][AXES][COEFFS];
    int coeffs_in_segment [MAX_SEGMENTS];

    // Free-running clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is abandoned if it goes on far longer than any correct run could.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("trajectory_polynomial_evaluator verification failed");
        $finish;
    end

    // Response side: checks each transaction, then decides whether to stall the next cycle.
    initial
    begin
        int hold_count;
        int hold_seen;
        kinematics_t got;
        hold_count = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = {rsp_ch.acc_z, rsp_ch.acc_y, rsp_ch.acc_x,
                       rsp_ch.vel_z, rsp_ch.vel_y, rsp_ch.vel_x,
                       rsp_ch.pos_z, rsp_ch.pos_y, rsp_ch.pos_x};
                sb.check_response(got);
            end
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                hold_count = HOLD_CYCLES;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Coefficients spread over extremes, full-range values and values scaled down by a shift.
    function automatic tpe_value_t rand_coefficient();
        tpe_value_t raw;
        raw = tpe_value_t'({$urandom, $urandom});
        case ($urandom_range(3))
            0: return raw;
            1:
            begin
                case ($urandom_range(4))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return '0;
                    3: return '1;
                    default: return VALUE_ONE;
                endcase
            end
            default: return raw >>> $urandom_range(VALUE_W - 1);
        endcase
    endfunction

    function automatic tpe_time_t rand_time();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return tpe_time_t'($urandom);
            3: return tpe_time_t'($urandom_range(16'hFFFF));
            default: return tpe_time_t'($urandom_range(20'h3FFFF));
        endcase
    endfunction

    function automatic request_t make_load(int seg, int ax, int pw, tpe_value_t c);
        request_t r;
        r.operation   = OP_LOAD;
        r.segment     = tpe_seg_t'(seg);
        r.axis        = tpe_axis_t'(ax);
        r.power       = tpe_power_t'(pw);
        r.coefficient = c;
        r.local_time  = tpe_time_t'($urandom);
        return r;
    endfunction

    // A query carries random values in the fields that only a load uses.
    function automatic request_t make_query(int seg, tpe_time_t t);
        request_t r;
        r.operation   = OP_QUERY;
        r.segment     = tpe_seg_t'(seg);
        r.axis        = tpe_axis_t'($urandom_range(3));
        r.power       = tpe_power_t'($urandom_range(7));
        r.coefficient = tpe_value_t'({$urandom, $urandom});
        r.local_time  = t;
        return r;
    endfunction

    // Offers one request transaction after optional idle cycles and waits for its acceptance.
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= r.operation;
        req_ch.segment     <= r.segment;
        req_ch.axis        <= r.axis;
        req_ch.power       <= r.power;
        req_ch.coefficient <= r.coefficient;
        req_ch.local_time  <= r.local_time;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(r);
        if (!(r.operation == OP_LOAD && r.axis >= AXES))
            counted++;
    endtask

    // Loads one coefficient and records which table entries now hold a value.
    task automatic load_coefficient(int seg, int ax, int pw, tpe_value_t c);
        send_request(make_load(seg, ax, pw, c));
        if (ax < AXES && !coeff_loaded[seg][ax][pw])
        begin
            coeff_loaded[seg][ax][pw] = 1'b1;
            coeffs_in_segment[seg]++;
        end
    endtask

    task automatic fill_segment(int seg);
        int ax;
        int pw;
        for (ax = 0; ax < AXES; ax++)
            for (pw = 0; pw < COEFFS; pw++)
                load_coefficient(seg, ax, pw, rand_coefficient());
    endtask

    // Queries only segments whose every coefficient has been loaded.
    task automatic query_loaded_segment();
        int complete [$];
        int seg;
        for (seg = 0; seg < MAX_SEGMENTS; seg++)
            if (coeffs_in_segment[seg] == AXES * COEFFS)
                complete.push_back(seg);
        if (complete.size() == 0)
            fill_segment($urandom_range(MAX_SEGMENTS - 1));
        else
            send_request(make_query(complete[$urandom_range(complete.size() - 1)], rand_time()));
    endtask

    // Stimulus and end of run.
    initial
    begin
        int ax;
        int pw;
        int choice;
        bit pressure_done;
        tpe_value_t c;
        pressure_done = 1'b0;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_LOAD;
        req_ch.segment     <= '0;
        req_ch.axis        <= '0;
        req_ch.power       <= '0;
        req_ch.coefficient <= '0;
        req_ch.local_time  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Top segment: x saturates high, y saturates low, z stays in range with mixed signs.
        for (ax = 0; ax < AXES; ax++)
        begin
            for (pw = 0; pw < COEFFS; pw++)
            begin
                if (ax == 0)
                    c = VALUE_MAX;
                else if (ax == 1)
                    c = VALUE_MIN;
                else
                    c = pw[0] ? tpe_value_t'('1) : VALUE_ONE;
                load_coefficient(MAX_SEGMENTS - 1, ax, pw, c);
            end
        end
        // A load to the fourth axis must leave the table untouched.
        send_request(make_load(MAX_SEGMENTS - 1, AXES, COEFFS - 1, 48'h1234_5678_9ABC));
        send_request(make_query(MAX_SEGMENTS - 1, '0));
        send_request(make_query(MAX_SEGMENTS - 1, '1));
        send_request(make_query(MAX_SEGMENTS - 1, tpe_time_t'(20'h10000)));
        send_request(make_query(MAX_SEGMENTS - 1, tpe_time_t'(20'h08000)));

        // Random part in four idling mixes, with one long output hold in the first.
        while (counted < TOTAL_ITEMS)
        begin
            case ((counted * 4) / TOTAL_ITEMS)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            if (!pressure_done && counted >= 120)
            begin
                pressure_done = 1'b1;
                hold_ask++;
                repeat (8) query_loaded_segment();
            end
            choice = $urandom_range(99);
            if (choice < 8)
                fill_segment($urandom_range(MAX_SEGMENTS - 1));
            else if (choice < 20)
                load_coefficient($urandom_range(MAX_SEGMENTS - 1), $urandom_range(3),
                                 $urandom_range(COEFFS - 1), rand_coefficient());
            else
                query_loaded_segment();
        end
        req_ch.valid <= 1'b0;

        // Let every predicted result arrive, then watch for stray ones.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d coefficient loads (%0d to the unused axis) and %0d queries,",
                 sb.loads, sb.ignored_loads, sb.queries);
        $display("%0d results compared in nine fields, %0d saturating Horner steps, four idling mixes.",
                 sb.checked, sb.saturations);
        if (sb.errors == 0)
            $display("trajectory_polynomial_evaluator verification clean");
        else
            $display("trajectory_polynomial_evaluator verification failed");
        $finish;
    end

endmodule
